[src/lfrd_pkg.sv]
`timescale 1ns / 1ps

package lfrd_pkg;

    localparam int MAX_RESOURCES_DEF = 16;
    localparam int START_W           = 32;
    localparam int TIME_W            = 48;
    localparam int COUNT_W           = 32;
    localparam int RES_W             = 4;
    localparam int CFG_W             = 5;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [START_W-1:0] start_time;
        logic [START_W-1:0] end_time;
        logic               last_job;
    } job_t;

    typedef struct packed {
        logic [RES_W-1:0]  resource_assigned;
        logic [TIME_W-1:0] actual_start;
        logic [RES_W-1:0]  busiest_resource;
        logic              batch_done;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_COMMIT
    } state_t;

endpackage

[src/lowest_free_room_dispatcher_unit.sv]
`timescale 1ns / 1ps

// channel   valid       ready       payload
// job       job_valid   job_ready   job         (lfrd_pkg::job_t)
// result    res_valid   res_ready   res         (lfrd_pkg::result_t)
// config    cfg_wr_en   -           cfg_wr_data (resources_in_use)
//
// A job is accepted in idle, then scanned with one read of the free-time and use-count
// memories per active resource; a tail state covers the registered read, and then comes
// one read-modify-write commit. No new job is accepted before that commit fires.
// Reset clears the per-entry valid bits at once; the last job of a batch does the same.
// A stalled result beat holds the commit cycle; no new job is taken while it waits.
module lowest_free_room_dispatcher_unit #(
    parameter int MAX_RESOURCES = lfrd_pkg::MAX_RESOURCES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    output logic                        job_ready,
    input  lfrd_pkg::job_t              job,
    output logic                        res_valid,
    input  logic                        res_ready,
    output lfrd_pkg::result_t           res,
    input  logic                        cfg_wr_en,
    input  logic [lfrd_pkg::CFG_W-1:0]  cfg_wr_data
);
    import lfrd_pkg::*;

    localparam int IDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

    logic [TIME_W-1:0]  ft_mem  [MAX_RESOURCES];
    logic [COUNT_W-1:0] cnt_mem [MAX_RESOURCES];

    state_t state_reg, state_next;

    logic [CFG_W-1:0]         cfg_reg;
    logic [IDX_W-1:0]         last_idx;
    job_t                     job_reg;
    logic [MAX_RESOURCES-1:0] ent_vld_reg;

    logic [IDX_W-1:0]   scan_cnt_reg;
    logic               chk_vld_reg;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic [TIME_W-1:0]  ft_rd_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic               vld_rd_reg;
    logic [TIME_W-1:0]  ft_eff;
    logic [COUNT_W-1:0] cnt_eff;

    logic               found_reg,    found_next;
    logic [IDX_W-1:0]   pick_reg,     pick_next;
    logic [TIME_W-1:0]  pick_ft_reg,  pick_ft_next;
    logic [COUNT_W-1:0] pick_cnt_reg, pick_cnt_next;
    logic [IDX_W-1:0]   best_reg,     best_next;
    logic [COUNT_W-1:0] best_cnt_reg, best_cnt_next;

    logic               accept;
    logic               scan_en;
    logic               commit_fire;
    logic               mem_we;
    logic [TIME_W-1:0]  start_ext;
    logic [START_W-1:0] dur;
    logic [TIME_W-1:0]  begin_time;
    logic [TIME_W:0]    end_sum;
    logic [TIME_W-1:0]  ft_wdata;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [IDX_W-1:0]   busiest;

    logic               res_valid_reg;
    result_t            res_reg;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            last_idx = '0;
        end
        else if (int'(cfg_reg) > MAX_RESOURCES)
        begin
            last_idx = IDX_W'(MAX_RESOURCES - 1);
        end
        else
        begin
            last_idx = IDX_W'(cfg_reg - CFG_W'(1));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == last_idx)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        job_ready   = 1'b0;
        scan_en     = 1'b0;
        commit_fire = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
            end
            ST_SCAN:
            begin
                scan_en = 1'b1;
            end
            ST_TAIL:
            begin
            end
            ST_COMMIT:
            begin
                commit_fire = !res_valid_reg || res_ready;
            end
            default:
            begin
            end
        endcase
    end

    assign accept = job_valid && job_ready;
    assign mem_we = commit_fire && !job_reg.last_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= CFG_RESET;
            ent_vld_reg  <= '0;
            scan_cnt_reg <= '0;
            chk_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= scan_en;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                scan_cnt_reg <= '0;
            end
            else if (scan_en)
            begin
                scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
            end
            if (commit_fire)
            begin
                if (job_reg.last_job)
                begin
                    ent_vld_reg <= '0;
                end
                else
                begin
                    ent_vld_reg[pick_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job;
        end
        chk_idx_reg <= scan_cnt_reg;
        vld_rd_reg  <= ent_vld_reg[scan_cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ft_mem[pick_reg] <= ft_wdata;
        end
        if (scan_en)
        begin
            ft_rd_reg <= ft_mem[scan_cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[pick_reg] <= cnt_wdata;
        end
        if (scan_en)
        begin
            cnt_rd_reg <= cnt_mem[scan_cnt_reg];
        end
    end

    assign ft_eff    = vld_rd_reg ? ft_rd_reg : '0;
    assign cnt_eff   = vld_rd_reg ? cnt_rd_reg : '0;
    assign start_ext = TIME_W'(job_reg.start_time);

    // track first free entry, earliest release and busiest entry
    always_comb
    begin
        found_next    = found_reg;
        pick_next     = pick_reg;
        pick_ft_next  = pick_ft_reg;
        pick_cnt_next = pick_cnt_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        if (accept)
        begin
            found_next = 1'b0;
        end
        else if (chk_vld_reg)
        begin
            if (!found_reg)
            begin
                if (ft_eff <= start_ext)
                begin
                    found_next    = 1'b1;
                    pick_next     = chk_idx_reg;
                    pick_cnt_next = cnt_eff;
                end
                else if (chk_idx_reg == '0 || ft_eff < pick_ft_reg)
                begin
                    pick_next     = chk_idx_reg;
                    pick_ft_next  = ft_eff;
                    pick_cnt_next = cnt_eff;
                end
            end
            if (chk_idx_reg == '0 || cnt_eff > best_cnt_reg)
            begin
                best_next     = chk_idx_reg;
                best_cnt_next = cnt_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg     <= pick_next;
        pick_ft_reg  <= pick_ft_next;
        pick_cnt_reg <= pick_cnt_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
    end

    always_comb
    begin
        dur        = (job_reg.end_time > job_reg.start_time)
                   ? (job_reg.end_time - job_reg.start_time) : '0;
        begin_time = found_reg ? start_ext : pick_ft_reg;
        end_sum    = {1'b0, begin_time} + (TIME_W + 1)'(dur);
        ft_wdata   = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
        cnt_wdata  = (pick_cnt_reg == COUNT_MAX) ? COUNT_MAX : pick_cnt_reg + COUNT_W'(1);
        if (cnt_wdata > best_cnt_reg || (cnt_wdata == best_cnt_reg && pick_reg < best_reg))
        begin
            busiest = pick_reg;
        end
        else
        begin
            busiest = best_reg;
        end
    end

    // hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (commit_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_fire)
        begin
            res_reg.resource_assigned <= RES_W'(pick_reg);
            res_reg.actual_start      <= begin_time;
            res_reg.busiest_resource  <= job_reg.last_job ? RES_W'(busiest) : '0;
            res_reg.batch_done        <= job_reg.last_job;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
